FILE: hdl/wvpp_pkg.sv
package wvpp_pkg;

  // Pipeline stage indexes
  localparam int ST_LOAD  = 0;
  localparam int ST_SUM   = 1;
  localparam int ST_NUM   = 2;
  localparam int ST_MUL   = 3;
  localparam int ST_OUT   = 4;
  localparam int STAGES   = 5;

  // Result field width and packed output beat width
  localparam int OUT_W       = 14;
  localparam int OUT_TDATA_W = 32;

  // Per-beat control from the handshake logic to each axis datapath
  typedef struct packed {
    logic              clear;  // history empty before this position
    logic              full;   // oldest entry drops out of the window
    logic [STAGES-1:0] adv;    // stage register loads this cycle
  } wvpp_ctrl_t;

endpackage

FILE: hdl/weighted_velocity_position_predictor.sv
// Channel  Dir  Bits                       Content
// s_*      in   tdata[2*CW-1:0], tuser[1:0] pos_x, pos_y ; new_track, parked
// m_*      out  tdata[27:0]                pred_x, pred_y
//
// One beat in per cycle while s_tready is high. Each beat passes through the
// five-stage datapath (load, sum, numerator, reciprocal multiply, final add),
// each stage a register, so a new beat enters while earlier ones are in flight.
// rst clears the fill count and every stage valid; history is unknown until
// written. A stage holds its beat while the next one is full and stalled, so
// s_tready drops only once all five stages hold beats behind a stalled output.
module weighted_velocity_position_predictor import wvpp_pkg::*; #(
  parameter int HISTORY_DEPTH = 10,
  parameter int COORD_WIDTH   = 12
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  // pos_x, pos_y from bit 0, zero padded to bytes
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]         s_tdata,
  // new_track, parked from bit 0
  input  logic [1:0]                                 s_tuser,
  output logic                                       m_tvalid,
  input  logic                                       m_tready,
  // pred_x, pred_y from bit 0, zero padded
  output logic [OUT_TDATA_W-1:0]                     m_tdata
);

  localparam int D  = HISTORY_DEPTH;
  localparam int CW = COORD_WIDTH;
  localparam int MW = $clog2(D);
  localparam int FW = $clog2(D + 1);

  logic [CW-1:0]     pos_x;
  logic [CW-1:0]     pos_y;
  logic              new_track;
  logic              parked;

  assign pos_x     = s_tdata[CW-1:0];
  assign pos_y     = s_tdata[2*CW-1:CW];
  assign new_track = s_tuser[0];
  assign parked    = s_tuser[1];

  // Stage valids and ready chain
  logic [STAGES-1:0] v;
  logic [STAGES-1:0] rdy;
  wvpp_ctrl_t        ctrl;

  always_comb begin
    rdy[STAGES-1] = ~v[STAGES-1] | m_tready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      rdy[k] = ~v[k] | rdy[k+1];
    end
  end

  assign s_tready = rdy[ST_LOAD];
  assign m_tvalid = v[ST_OUT];

  // Fill tracking and window span for the beat being accepted
  logic [FW-1:0]     fill;
  logic [FW-1:0]     fill_eff;
  logic [FW-1:0]     fill_next;
  logic [MW-1:0]     m_in;
  logic              accept;

  assign accept = s_tvalid & s_tready;

  always_comb begin
    fill_eff  = new_track ? '0 : fill;
    ctrl.full  = (fill_eff == FW'(D));
    ctrl.clear = (fill_eff == '0);
    m_in      = ctrl.full ? MW'(D - 1) : fill_eff[MW-1:0];
    fill_next = ctrl.full ? fill_eff : fill_eff + FW'(1);
    ctrl.adv[ST_LOAD] = accept;
    for (int k = 1; k < STAGES; k++) begin
      ctrl.adv[k] = v[k-1] & rdy[k];
    end
  end

  // Advance valids and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      v    <= '0;
      fill <= '0;
    end else begin
      if (rdy[ST_LOAD]) begin
        v[ST_LOAD] <= s_tvalid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
      if (accept) begin
        fill <= fill_next;
      end
    end
  end

  logic [OUT_W-1:0]  pred_x;
  logic [OUT_W-1:0]  pred_y;

  wvpp_axis #(.CW(CW), .D(D)) u_axis_x (
    .clk    (clk),
    .ctrl   (ctrl),
    .pos    (pos_x),
    .m      (m_in),
    .parked (parked),
    .pred   (pred_x)
  );

  wvpp_axis #(.CW(CW), .D(D)) u_axis_y (
    .clk    (clk),
    .ctrl   (ctrl),
    .pos    (pos_y),
    .m      (m_in),
    .parked (parked),
    .pred   (pred_y)
  );

  assign m_tdata = {{(OUT_TDATA_W - 2*OUT_W){1'b0}}, pred_y, pred_x};

  // A restarted track holds exactly one position
  a_restart_fill: assert property (@(posedge clk) disable iff (rst)
    accept && new_track |=> fill == FW'(1))
    else $error("fill count wrong after new track");

  // A full window stays full while the track continues
  a_full_stays: assert property (@(posedge clk) disable iff (rst)
    accept && !new_track && fill == FW'(D) |=> fill == FW'(D))
    else $error("full window lost an entry");

  // Input stalls only when every stage holds a beat behind a stalled output
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (&v) && !m_tready)
    else $error("input stalled with a free stage");

  // An accepted beat occupies the load stage next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    accept |=> v[ST_LOAD])
    else $error("accepted beat missing from load stage");

endmodule

FILE: hdl/wvpp_axis.sv
module wvpp_axis import wvpp_pkg::*; #(
  parameter int CW = 12,
  parameter int D  = 10
) (
  input  logic                   clk,
  input  wvpp_ctrl_t             ctrl,
  input  logic [CW-1:0]          pos,
  input  logic [$clog2(D)-1:0]   m,
  input  logic                   parked,
  output logic [OUT_W-1:0]       pred
);

  localparam int MW   = $clog2(D);
  localparam int TW   = CW + $clog2(D + 1);
  localparam int SUMW = CW + $clog2(D);
  localparam int SW   = SUMW + 1;
  localparam int NW   = SUMW + 2;
  localparam int DW   = $clog2(D * (D - 1));
  localparam int K    = NW + DW;
  localparam int PW   = NW + K;
  localparam int RW   = CW + 2;

  // Divisor and reciprocal tables indexed by window span m
  logic [NW-1:0] den_tab   [D];
  logic [K-1:0]  recip_tab [D];

  assign den_tab[0]   = '0;
  assign recip_tab[0] = '0;

  for (genvar j = 1; j < D; j++) begin : g_tab
    localparam longint unsigned DD = longint'(j) * longint'(j + 1);
    localparam longint unsigned RC = ((64'd1 << K) + DD - 64'd1) / DD;
    assign den_tab[j]   = NW'(DD >> 1);
    assign recip_tab[j] = K'(RC);
  end

  // History shift line, newest at tap 0, and running sum of the window
  logic [CW-1:0]   hist [D];
  logic [TW-1:0]   total;
  logic [TW-1:0]   base;
  logic [TW-1:0]   evict;
  logic [TW-1:0]   older_sum;
  logic [TW-1:0]   total_next;

  always_comb begin
    base       = ctrl.clear ? '0 : total;
    evict      = ctrl.full ? TW'(hist[D-1]) : '0;
    older_sum  = base - evict;
    total_next = older_sum + TW'(pos);
  end

  // Load stage: capture position, span and sum of the older positions
  logic [CW-1:0]   p0;
  logic [MW-1:0]   m0;
  logic            b0;
  logic [SUMW-1:0] older0;

  always_ff @(posedge clk) begin
    if (ctrl.adv[ST_LOAD]) begin
      hist[0] <= pos;
      for (int i = 1; i < D; i++) begin
        hist[i] <= hist[i-1];
      end
      total  <= total_next;
      p0     <= pos;
      m0     <= m;
      b0     <= parked | (m == '0);
      older0 <= older_sum[SUMW-1:0];
    end
  end

  // Weighted delta sum collapses to m * newest minus the older positions
  logic [SUMW-1:0] mp;
  logic [SW-1:0]   s_next;
  logic [CW-1:0]   p1;
  logic [MW-1:0]   m1;
  logic            b1;
  logic [SW-1:0]   s1;

  assign mp     = SUMW'(m0) * SUMW'(p0);
  assign s_next = SW'(mp) - SW'(older0);

  always_ff @(posedge clk) begin
    if (ctrl.adv[ST_SUM]) begin
      p1 <= p0;
      m1 <= m0;
      b1 <= b0;
      s1 <= s_next;
    end
  end

  // Form the rounding numerator 2|S| + den
  logic [SW-1:0]   mag;
  logic [NW-1:0]   n_next;
  logic [CW-1:0]   p2;
  logic [MW-1:0]   m2;
  logic            b2;
  logic            neg2;
  logic [NW-1:0]   n2;

  assign mag    = s1[SW-1] ? (~s1 + SW'(1)) : s1;
  assign n_next = (NW'(mag[SUMW-1:0]) << 1) + den_tab[m1];

  always_ff @(posedge clk) begin
    if (ctrl.adv[ST_NUM]) begin
      p2   <= p1;
      m2   <= m1;
      b2   <= b1;
      neg2 <= s1[SW-1];
      n2   <= n_next;
    end
  end

  // Divide by 2*den through the reciprocal table
  logic [PW-1:0]   prod;
  logic [CW-1:0]   p3;
  logic            b3;
  logic            neg3;
  logic [CW-1:0]   q3;

  assign prod = PW'(n2) * PW'(recip_tab[m2]);

  always_ff @(posedge clk) begin
    if (ctrl.adv[ST_MUL]) begin
      p3   <= p2;
      b3   <= b2;
      neg3 <= neg2;
      q3   <= prod[K +: CW];
    end
  end

  // Add the signed mean delta to the newest position; the delta is zero when parked or with no older position
  logic signed [RW-1:0] delta;
  logic signed [RW-1:0] res;

  always_comb begin
    if (b3) begin
      delta = '0;
    end else if (neg3) begin
      delta = -$signed(RW'(q3));
    end else begin
      delta = $signed(RW'(q3));
    end
    res = $signed(RW'(p3)) + delta;
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv[ST_OUT]) begin
      pred <= OUT_W'(res);
    end
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top import wvpp_pkg::*; ();

  localparam int HD       = 10;
  localparam int CW       = 12;
  localparam int DATA_W   = ((2*CW+7)/8)*8;
  localparam int WATCHDOG = 4000;
  localparam int N_DIR    = 23;
  localparam int N_RAND   = 1900;
  localparam int SETTLE   = 20;

  // tuser bit positions
  localparam int NT_BIT = 0;
  localparam int PK_BIT = 1;

  // directed stimulus row; ex/ey are used only when chk is set
  typedef struct packed {
    logic [CW-1:0]           x;
    logic [CW-1:0]           y;
    bit                      nt;
    bit                      pk;
    bit                      chk;
    logic signed [OUT_W-1:0] ex;
    logic signed [OUT_W-1:0] ey;
  } dir_row_t;

  dir_row_t dir_tab [0:N_DIR-1] = '{
    // first beat after reset, then full-scale swings
    '{12'd0,    12'd0,    1'b0, 1'b0, 1'b1, 14'sd0,     14'sd0},
    '{12'd4095, 12'd4095, 1'b0, 1'b0, 1'b1, 14'sd8190,  14'sd8190},
    '{12'd0,    12'd0,    1'b0, 1'b0, 1'b0, 14'sd0,     14'sd0},
    // new track, opposite swings per axis
    '{12'd4095, 12'd0,    1'b1, 1'b0, 1'b1, 14'sd4095,  14'sd0},
    '{12'd0,    12'd4095, 1'b0, 1'b0, 1'b1, -14'sd4095, 14'sd8190},
    // parked on a fresh track and with history
    '{12'd100,  12'd200,  1'b1, 1'b1, 1'b1, 14'sd100,   14'sd200},
    '{12'd110,  12'd190,  1'b0, 1'b1, 1'b1, 14'sd110,   14'sd190},
    // uneven ramp that runs past a full history
    '{12'd123,  12'd186,  1'b0, 1'b0, 1'b0, 14'sd0,     14'sd0},
    '{12'd130,  12'd181,  1'b0, 1'b0, 1'b0, 14'sd0,     14'sd0},
    '{12'd150,  12'd170,  1'b0, 1'b0, 1'b0, 14'sd0,     14'sd0},
    '{12'd161,  12'd168,  1'b0, 1'b0, 1'b0, 14'sd0,     14'sd0},
    '{12'd190,  12'd150,  1'b0, 1'b0, 1'b0, 14'sd0,     14'sd0},
    '{12'd192,  12'd149,  1'b0, 1'b0, 1'b0, 14'sd0,     14'sd0},
    '{12'd230,  12'd120,  1'b0, 1'b0, 1'b0, 14'sd0,     14'sd0},
    '{12'd231,  12'd117,  1'b0, 1'b0, 1'b0, 14'sd0,     14'sd0},
    '{12'd260,  12'd100,  1'b0, 1'b0, 1'b0, 14'sd0,     14'sd0},
    '{12'd275,  12'd90,   1'b0, 1'b0, 1'b0, 14'sd0,     14'sd0},
    '{12'd300,  12'd60,   1'b0, 1'b1, 1'b0, 14'sd0,     14'sd0},
    '{12'd302,  12'd58,   1'b0, 1'b0, 1'b0, 14'sd0,     14'sd0},
    // exact halves: x rounds up to +2, y down to -2
    '{12'd0,    12'd10,   1'b1, 1'b0, 1'b0, 14'sd0,     14'sd0},
    '{12'd0,    12'd10,   1'b0, 1'b0, 1'b0, 14'sd0,     14'sd0},
    '{12'd0,    12'd10,   1'b0, 1'b0, 1'b0, 14'sd0,     14'sd0},
    '{12'd3,    12'd7,    1'b0, 1'b0, 1'b0, 14'sd0,     14'sd0}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [DATA_W-1:0]      s_tdata = '0;
  logic [1:0]             s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  // typed expectation that travels with the current beat
  bit                     typed_chk = 1'b0;
  logic [2*OUT_W-1:0]     typed_pred = '0;

  // track state: history per axis, fill count, newest slot
  logic [CW-1:0]          hist [0:1][0:HD-1];
  int                     fill;
  int                     head;

  logic [2*OUT_W-1:0]     pending_pred [$];
  logic [2*OUT_W-1:0]     want;
  int                     mismatches;
  int                     idle_cycles;
  int                     burst_left;
  int                     rx_cyc;
  int                     rx_mode;

  weighted_velocity_position_predictor #(
    .HISTORY_DEPTH(HD),
    .COORD_WIDTH  (CW)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // newest position plus the weighted mean delta of one axis, rounded half away from zero
  function automatic logic [OUT_W-1:0] extrapolate(input int axis, input int m, input bit pk);
    int total;
    int den;
    int q;
    int a;
    int b;
    int v;
    if (pk || m == 0) return OUT_W'(hist[axis][head]);
    total = 0;
    for (int i = 1; i <= m; i++) begin
      a = hist[axis][(head + HD - (m - i)) % HD];
      b = hist[axis][(head + HD - (m - i + 1)) % HD];
      total += i * (a - b);
    end
    den = m * (m + 1) / 2;
    if (total >= 0) q = (2 * total + den) / (2 * den);
    else q = -((-2 * total + den) / (2 * den));
    v = int'(hist[axis][head]) + q;
    return v[OUT_W-1:0];
  endfunction

  // store one position and return {pred_y, pred_x}
  function automatic logic [2*OUT_W-1:0] advance_track(input logic [CW-1:0] px, py,
                                                       input bit nt, pk);
    logic [OUT_W-1:0] ox;
    logic [OUT_W-1:0] oy;
    if (nt) fill = 0;
    if (fill != 0) head = (head + 1) % HD;
    hist[0][head] = px;
    hist[1][head] = py;
    if (fill < HD) fill++;
    ox = extrapolate(0, fill - 1, pk);
    oy = extrapolate(1, fill - 1, pk);
    return {oy, ox};
  endfunction

  // drive one beat, wait for its handshake, then idle between bursts
  task automatic push_position(input logic [CW-1:0] px, py, input bit nt, pk,
                               input bit chk, input logic [2*OUT_W-1:0] typed);
    int gap;
    @(negedge clk);
    s_tvalid   <= 1'b1;
    s_tdata    <= DATA_W'({py, px});
    s_tuser    <= {pk, nt};
    typed_chk  <= chk;
    typed_pred <= typed;
    do @(posedge clk); while (!s_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(100, 300);
      else burst_left = $urandom_range(0, 20);
    end
  endtask

  // hold the sender off until every expected beat has come out
  task automatic hold_until_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_pred.size() != 0) @(posedge clk);
  endtask

  // receiver backpressure: the pattern steps through four modes in turn
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_cyc   <= 0;
    end else begin
      rx_mode = (rx_cyc / 256) % 4;
      case (rx_mode)
        0: begin
          m_tready <= 1'b1;
        end
        1: begin
          m_tready <= ($urandom_range(0, 3) != 0);
        end
        2: begin
          m_tready <= (rx_cyc % 7 < 3);
        end
        default: begin
          m_tready <= (rx_cyc % 16 == 0);
        end
      endcase
      rx_cyc <= rx_cyc + 1;
    end
  end

  // predict accepted inputs, check accepted outputs, run the watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        want = advance_track(s_tdata[CW-1:0], s_tdata[2*CW-1:CW],
                             s_tuser[NT_BIT], s_tuser[PK_BIT]);
        pending_pred = {pending_pred, (typed_chk ? typed_pred : want)};
      end
      if (m_tvalid && m_tready) begin
        if (pending_pred.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result beat: pred_x=%0d pred_y=%0d",
                     $signed(m_tdata[OUT_W-1:0]), $signed(m_tdata[2*OUT_W-1:OUT_W]));
          mismatches++;
        end else begin
          want = pending_pred.pop_front();
          if (m_tdata[OUT_W-1:0] !== want[OUT_W-1:0] ||
              m_tdata[2*OUT_W-1:OUT_W] !== want[2*OUT_W-1:OUT_W]) begin
            if (mismatches < 10)
              $display("mismatch: pred_x exp %0d got %0d, pred_y exp %0d got %0d",
                       $signed(want[OUT_W-1:0]), $signed(m_tdata[OUT_W-1:0]),
                       $signed(want[2*OUT_W-1:OUT_W]),
                       $signed(m_tdata[2*OUT_W-1:OUT_W]));
            mismatches++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    int kind;
    int len;
    int cx;
    int cy;
    int vx;
    int vy;
    bit nt;
    bit paused;
    fill        = 0;
    head        = 0;
    mismatches  = 0;
    idle_cycles = 0;
    burst_left  = 0;
    paused      = 1'b0;
    for (int i = 0; i < HD; i++) begin
      hist[0][i] = '0;
      hist[1][i] = '0;
    end

    // hold reset, release away from the sampling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < N_DIR; i++)
      push_position(dir_tab[i].x, dir_tab[i].y, dir_tab[i].nt, dir_tab[i].pk,
                    dir_tab[i].chk, {dir_tab[i].ey, dir_tab[i].ex});
    hold_until_drained();

    // random tracks, mostly smooth motion, some noise and broken tracks
    sent = 0;
    while (sent < N_RAND) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        push_position(CW'($urandom), CW'($urandom), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'b0, '0);
        sent++;
      end else if (kind == 1) begin
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) begin
          push_position(CW'($urandom), CW'($urandom), i == 0,
                        1'($urandom_range(0, 1)), 1'b0, '0);
          sent++;
        end
      end else begin
        len = $urandom_range(2, 30);
        cx  = $urandom_range(0, 4095);
        cy  = $urandom_range(0, 4095);
        if ($urandom_range(0, 15) == 0) begin
          vx = int'($urandom_range(0, 8190)) - 4095;
          vy = int'($urandom_range(0, 8190)) - 4095;
        end else begin
          vx = int'($urandom_range(0, 400)) - 200;
          vy = int'($urandom_range(0, 400)) - 200;
        end
        nt = ($urandom_range(0, 4) != 0);
        for (int i = 0; i < len; i++) begin
          vx += int'($urandom_range(0, 6)) - 3;
          vy += int'($urandom_range(0, 6)) - 3;
          cx += vx;
          cy += vy;
          if ($urandom_range(0, 7) == 0) begin
            cx = $urandom_range(0, 4095);
            cy = $urandom_range(0, 4095);
          end
          push_position(cx[CW-1:0], cy[CW-1:0], nt && i == 0,
                        $urandom_range(0, 9) == 0, 1'b0, '0);
          sent++;
        end
      end
      if (!paused && sent >= N_RAND / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
    end

    // drain, then let the pipeline settle
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_pred.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && pending_pred.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
